### sv/krpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krpc_pkg: shared types and constants of the key range partition collector
// Field widths, item and result records, mode and register codes.
// ----------------------------------------------------------------------------
package krpc_pkg;

	localparam int KEY_W      = 64;
	localparam int BYTE_W     = 48;
	localparam int REF_W      = 32;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;
	localparam int IN_DATA_W  = 2 * KEY_W + 2 * BYTE_W + 2 * REF_W;
	localparam int OUT_DATA_W = 2 * KEY_W + 2 * BYTE_W + 2 * REF_W;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};
	localparam logic [REF_W-1:0]  REF_MAX  = {REF_W{1'b1}};
	localparam logic [KEY_W-1:0]  KEY_MAX  = {KEY_W{1'b1}};

	// item modes
	localparam logic [MODE_W-1:0] MODE_LEAF   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INNER  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESID_B    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESID_R    = 2'd3;

	// classified item as held in the queue
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  first_key;
		logic [KEY_W-1:0]  last_key;
		logic [BYTE_W-1:0] range_bytes;
		logic [REF_W-1:0]  range_referents;
		logic [BYTE_W-1:0] possible_bytes;
		logic [REF_W-1:0]  possible_referents;
		logic [BYTE_W:0]   sum_bytes;
		logic [REF_W:0]    sum_referents;
	} item_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	// one emitted partition
	typedef struct packed {
		logic [KEY_W-1:0]  part_first_key;
		logic [KEY_W-1:0]  part_last_key;
		logic [BYTE_W-1:0] min_bytes;
		logic [BYTE_W-1:0] max_bytes;
		logic [REF_W-1:0]  min_referents;
		logic [REF_W-1:0]  max_referents;
		logic              is_final;
		logic              order_error;
	} result_t;

endpackage

### sv/krpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krpc_front: input stage of the partition collector
// Takes stream beats, drops unused modes, precomputes known plus possible
// sums and hands classified items to the queue.
// ----------------------------------------------------------------------------
module krpc_front
	import krpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic [MODE_W-1:0]    s_tuser,
	output logic                 push,
	output item_t                push_item,
	input  logic                 q_full
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_in;

	// unpack the beat
	always_comb begin
		item_in.mode               = s_tuser;
		item_in.first_key          = s_tdata[63:0];
		item_in.last_key           = s_tdata[127:64];
		item_in.range_bytes        = s_tdata[175:128];
		item_in.range_referents    = s_tdata[207:176];
		item_in.possible_bytes     = s_tdata[255:208];
		item_in.possible_referents = s_tdata[287:256];
		item_in.sum_bytes     = {1'b0, item_in.range_bytes} + {1'b0, item_in.possible_bytes};
		item_in.sum_referents = {1'b0, item_in.range_referents}
			+ {1'b0, item_in.possible_referents};
	end

	assign s_tready  = !valid_s1 || !q_full;
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	// stage register, unused mode never enters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid && (s_tuser != MODE_UNUSED);
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

endmodule

### sv/krpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krpc_queue: short item queue between front and back end
// Register based fifo, simultaneous push and pop allowed.
// ----------------------------------------------------------------------------
module krpc_queue
	import krpc_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	output logic    full,
	input  logic    pop,
	output q_head_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	item_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_pop;

	assign full       = (count_q == CNT_FULL);
	assign head.valid = (count_q != '0);
	assign head.item  = slots_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### sv/krpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krpc_back: walk state and partition cutting
// Holds configuration and walk state, takes one item per cycle unless the
// output is stalled, and keeps the emitted partition in an output register.
// ----------------------------------------------------------------------------
module krpc_back
	import krpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  q_head_t               head,
	output logic                  pop,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output result_t               res,
	output logic                  res_valid,
	input  logic                  res_ready
);

	// configuration
	logic [BYTE_W-1:0] limit_b_q;
	logic [REF_W-1:0]  limit_r_q;
	logic [BYTE_W-1:0] resid_cfg_b_q;
	logic [REF_W-1:0]  resid_cfg_r_q;

	// walk state
	logic [KEY_W-1:0]  exp_key_q;
	logic [KEY_W-1:0]  open_key_q;
	logic [BYTE_W-1:0] known_b_q;
	logic [REF_W-1:0]  known_r_q;
	logic [BYTE_W-1:0] carr_b_q;
	logic [REF_W-1:0]  carr_r_q;
	logic [BYTE_W-1:0] resid_b_q;
	logic [REF_W-1:0]  resid_r_q;
	logic              any_emit_q;

	logic    res_valid_q;
	result_t res_q;

	item_t             it;
	logic              out_free;
	logic              step;
	logic [BYTE_W:0]   kb_raw;
	logic [REF_W:0]    kr_raw;
	logic [BYTE_W-1:0] kb_sat;
	logic [REF_W-1:0]  kr_sat;
	logic [BYTE_W+2:0] worst_b;
	logic [REF_W+2:0]  worst_r;
	logic [BYTE_W+1:0] maxb_raw;
	logic [REF_W+1:0]  maxr_raw;
	logic [BYTE_W-1:0] maxb_sat;
	logic [REF_W-1:0]  maxr_sat;
	logic [BYTE_W:0]   finb_raw;
	logic [REF_W:0]    finr_raw;
	logic              hit;
	logic              order_err;
	logic              cut_emit;
	logic [KEY_W-1:0]  last_next;
	logic              new_res;
	result_t           new_res_d;

	assign it       = head.item;
	assign out_free = !res_valid_q || res_ready;
	assign pop      = out_free;
	assign step     = head.valid && out_free;

	// leaf arithmetic: saturated known counts and worst case against the limits
	always_comb begin
		kb_raw   = {1'b0, known_b_q} + {1'b0, it.range_bytes};
		kr_raw   = {1'b0, known_r_q} + {1'b0, it.range_referents};
		kb_sat   = kb_raw[BYTE_W] ? BYTE_MAX : kb_raw[BYTE_W-1:0];
		kr_sat   = kr_raw[REF_W] ? REF_MAX : kr_raw[REF_W-1:0];
		worst_b  = {3'b0, known_b_q} + {2'b0, it.sum_bytes} + {3'b0, carr_b_q}
			+ {3'b0, resid_b_q};
		worst_r  = {3'b0, known_r_q} + {2'b0, it.sum_referents} + {3'b0, carr_r_q}
			+ {3'b0, resid_r_q};
		maxb_raw = {2'b0, known_b_q} + {1'b0, it.sum_bytes} + {2'b0, carr_b_q};
		maxr_raw = {2'b0, known_r_q} + {1'b0, it.sum_referents} + {2'b0, carr_r_q};
		maxb_sat = (|maxb_raw[BYTE_W+1:BYTE_W]) ? BYTE_MAX : maxb_raw[BYTE_W-1:0];
		maxr_sat = (|maxr_raw[REF_W+1:REF_W]) ? REF_MAX : maxr_raw[REF_W-1:0];
		finb_raw = {1'b0, known_b_q} + {1'b0, carr_b_q};
		finr_raw = {1'b0, known_r_q} + {1'b0, carr_r_q};
		hit       = (worst_b >= {3'b0, limit_b_q}) || (worst_r >= {3'b0, limit_r_q});
		order_err = (it.first_key != exp_key_q);
		cut_emit  = hit && (kb_raw != '0);
		last_next = it.last_key + 64'd1;
	end

	// result selection
	always_comb begin
		new_res   = 1'b0;
		new_res_d = '0;
		case (it.mode)
			MODE_LEAF: begin
				if (cut_emit) begin
					new_res                  = 1'b1;
					new_res_d.part_first_key = open_key_q;
					new_res_d.part_last_key  = it.last_key;
					new_res_d.min_bytes      = kb_sat;
					new_res_d.max_bytes      = maxb_sat;
					new_res_d.min_referents  = kr_sat;
					new_res_d.max_referents  = maxr_sat;
					new_res_d.order_error    = order_err;
				end else if (order_err) begin
					new_res                  = 1'b1;
					new_res_d.part_first_key = it.first_key;
					new_res_d.part_last_key  = it.last_key;
					new_res_d.order_error    = 1'b1;
				end
			end
			MODE_FINISH: begin
				new_res_d.part_last_key = KEY_MAX;
				new_res_d.is_final      = 1'b1;
				if (known_b_q != '0) begin
					new_res                  = 1'b1;
					new_res_d.part_first_key = open_key_q;
					new_res_d.min_bytes      = known_b_q;
					new_res_d.max_bytes      = finb_raw[BYTE_W] ? BYTE_MAX
						: finb_raw[BYTE_W-1:0];
					new_res_d.min_referents  = known_r_q;
					new_res_d.max_referents  = finr_raw[REF_W] ? REF_MAX
						: finr_raw[REF_W-1:0];
				end else if (!any_emit_q) begin
					new_res = 1'b1;
				end
			end
			default: begin
				new_res = 1'b0;
			end
		endcase
	end

	// walk state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_b_q     <= '0;
			limit_r_q     <= '0;
			resid_cfg_b_q <= '0;
			resid_cfg_r_q <= '0;
			exp_key_q     <= '0;
			open_key_q    <= '0;
			known_b_q     <= '0;
			known_r_q     <= '0;
			carr_b_q      <= '0;
			carr_r_q      <= '0;
			resid_b_q     <= '0;
			resid_r_q     <= '0;
			any_emit_q    <= 1'b0;
		end else begin
			if (step) begin
				case (it.mode)
					MODE_LEAF: begin
						exp_key_q <= last_next;
						if (cut_emit) begin
							known_b_q  <= '0;
							known_r_q  <= '0;
							resid_b_q  <= '0;
							resid_r_q  <= '0;
							any_emit_q <= 1'b1;
						end else begin
							known_b_q <= kb_sat;
							known_r_q <= kr_sat;
						end
						if (hit) begin
							open_key_q <= last_next;
							carr_b_q   <= it.possible_bytes;
							carr_r_q   <= it.possible_referents;
						end
					end
					MODE_INNER: begin
						known_b_q <= kb_sat;
						known_r_q <= kr_sat;
					end
					MODE_FINISH: begin
						exp_key_q  <= '0;
						open_key_q <= '0;
						known_b_q  <= '0;
						known_r_q  <= '0;
						carr_b_q   <= '0;
						carr_r_q   <= '0;
						resid_b_q  <= resid_cfg_b_q;
						resid_r_q  <= resid_cfg_r_q;
						any_emit_q <= 1'b0;
					end
					default: begin
						any_emit_q <= any_emit_q;
					end
				endcase
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_BYTE_LIMIT: limit_b_q <= cfg_data[BYTE_W-1:0];
					REG_REF_LIMIT:  limit_r_q <= cfg_data[REF_W-1:0];
					REG_RESID_B: begin
						resid_cfg_b_q <= cfg_data[BYTE_W-1:0];
						if (!any_emit_q) begin
							resid_b_q <= cfg_data[BYTE_W-1:0];
						end
					end
					REG_RESID_R: begin
						resid_cfg_r_q <= cfg_data[REF_W-1:0];
						if (!any_emit_q) begin
							resid_r_q <= cfg_data[REF_W-1:0];
						end
					end
					default: begin
						limit_b_q <= limit_b_q;
					end
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= step && new_res;
		end
	end

	always_ff @(posedge clk) begin
		if (step && new_res) begin
			res_q <= new_res_d;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

### sv/key_range_partition_collector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_range_partition_collector_top: key range partition collector
// Cuts an ordered stream of key ranges into partitions bounded in bytes
// and referents.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless output back-pressure holds it,
// and gives at most one partition per item. The partition that a beat
// closes passes the front register, the queue and the output register. The
// rate is set by the walk stage, which updates the saturated known counts and
// compares the worst case against both limits for each item.
// Unused mode items are dropped at the input. The queue between front and
// back absorbs output stalls for QUEUE_DEPTH items. Configuration writes are
// taken every cycle and are meant to be issued only while the block is empty.
module key_range_partition_collector_top
	import krpc_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// first_key, last_key, range_bytes, range_referents, possible_bytes,
	// possible_referents
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode
	input  logic [MODE_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// part_first_key, part_last_key, min_bytes, max_bytes, min_referents,
	// max_referents
	output logic [OUT_DATA_W-1:0] m_tdata,
	// is_final
	output logic                  m_tlast,
	// order_error
	output logic                  m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic    push;
	item_t   push_item;
	logic    q_full;
	logic    pop;
	q_head_t head;
	result_t res;

	assign cfg_ready = 1'b1;

	krpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	krpc_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head)
	);

	krpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res),
		.res_valid (m_tvalid),
		.res_ready (m_tready)
	);

	// pack the result beat
	assign m_tdata = {res.max_referents, res.min_referents, res.max_bytes,
		res.min_bytes, res.part_last_key, res.part_first_key};
	assign m_tlast = res.is_final;
	assign m_tuser = res.order_error;

endmodule

### sv/krpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krpc_checker: port level checks of the partition collector
// Output handshake rules and partition consistency, bound to the top level.
// ----------------------------------------------------------------------------
module krpc_checker
	import krpc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast,
	input logic                  m_tuser
);

	// a stalled beat stays
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	// a stalled beat holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("output payload changed while stalled");

	// closing partition never flags an order error
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tuser)
		else $error("closing partition with order error");

	// closing partition reaches the top key
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[127:64] == KEY_MAX)
		else $error("closing partition does not end at top key");

	// sure counts never exceed worst case counts
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[175:128] <= m_tdata[223:176])
			&& (m_tdata[255:224] <= m_tdata[287:256]))
		else $error("min count above max count");

endmodule

bind key_range_partition_collector_top krpc_checker u_krpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

### dv/partition_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_checker: scoreboard for the key range partition collector
// Watches the item, partition and register channels. Keeps its own copy of
// the limits and walk state, computes the partition each item should close
// and compares every partition beat field by field with the oldest one due.
// ----------------------------------------------------------------------------
module partition_checker
	import krpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [MODE_W-1:0]     s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  m_tlast,
	input  logic                  m_tuser,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	// bit offsets inside the item and partition words
	localparam int IN_RB    = 2 * KEY_W;
	localparam int IN_RR    = IN_RB + BYTE_W;
	localparam int IN_PB    = IN_RR + REF_W;
	localparam int IN_PR    = IN_PB + BYTE_W;
	localparam int OUT_MINB = 2 * KEY_W;
	localparam int OUT_MAXB = OUT_MINB + BYTE_W;
	localparam int OUT_MINR = OUT_MAXB + BYTE_W;
	localparam int OUT_MAXR = OUT_MINR + REF_W;

	// register copies
	logic [BYTE_W-1:0] byte_limit;
	logic [REF_W-1:0]  ref_limit;
	logic [BYTE_W-1:0] resid_b;
	logic [REF_W-1:0]  resid_r;

	// walk state
	logic [KEY_W-1:0]  next_key;
	logic [KEY_W-1:0]  open_key;
	logic [BYTE_W-1:0] known_b;
	logic [REF_W-1:0]  known_r;
	logic [BYTE_W-1:0] carry_b;
	logic [REF_W-1:0]  carry_r;
	logic [BYTE_W-1:0] resid_b_left;
	logic [REF_W-1:0]  resid_r_left;
	logic              walk_emitted;

	result_t due_parts[$];
	int      mismatches = 0;

	assign fail_count = mismatches;

	function automatic logic [BYTE_W-1:0] clamp_b(input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] b);
		logic [BYTE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[BYTE_W] ? BYTE_MAX : s[BYTE_W-1:0];
	endfunction

	function automatic logic [REF_W-1:0] clamp_r(input logic [REF_W-1:0] a,
		input logic [REF_W-1:0] b);
		logic [REF_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[REF_W] ? REF_MAX : s[REF_W-1:0];
	endfunction

	function automatic result_t partition_of(input logic [KEY_W-1:0] fk,
		input logic [KEY_W-1:0] lk, input logic [BYTE_W-1:0] minb,
		input logic [BYTE_W-1:0] maxb, input logic [REF_W-1:0] minr,
		input logic [REF_W-1:0] maxr, input logic fin, input logic err);
		result_t p;
		p.part_first_key = fk;
		p.part_last_key  = lk;
		p.min_bytes      = minb;
		p.max_bytes      = maxb;
		p.min_referents  = minr;
		p.max_referents  = maxr;
		p.is_final       = fin;
		p.order_error    = err;
		return p;
	endfunction

	// append one partition to the due list
	task automatic add_due(input result_t p);
		due_parts = {due_parts, p};
	endtask

	task automatic start_walk();
		next_key     = '0;
		open_key     = '0;
		known_b      = '0;
		known_r      = '0;
		carry_b      = '0;
		carry_r      = '0;
		resid_b_left = resid_b;
		resid_r_left = resid_r;
		walk_emitted = 1'b0;
	endtask

	// advance the walk by one item and queue the partition it closes, if any
	task automatic predict_partition(input logic [MODE_W-1:0] mode,
		input logic [KEY_W-1:0] fk, input logic [KEY_W-1:0] lk,
		input logic [BYTE_W-1:0] rb, input logic [REF_W-1:0] rr,
		input logic [BYTE_W-1:0] pb, input logic [REF_W-1:0] pr);
		logic              out_of_order;
		logic              cut_given;
		logic [BYTE_W-1:0] worst_b;
		logic [REF_W-1:0]  worst_r;
		cut_given = 1'b0;
		case (mode)
			MODE_LEAF: begin
				out_of_order = (fk != next_key);
				known_b = clamp_b(known_b, rb);
				known_r = clamp_r(known_r, rr);
				worst_b = clamp_b(clamp_b(known_b, pb), carry_b);
				worst_r = clamp_r(clamp_r(known_r, pr), carry_r);
				// the residual only weighs on the cut decision, never on max
				if (clamp_b(worst_b, resid_b_left) >= byte_limit ||
						clamp_r(worst_r, resid_r_left) >= ref_limit) begin
					// a cut with no known bytes moves the key but gives nothing
					if (known_b != '0) begin
						add_due(partition_of(open_key, lk, known_b, worst_b,
							known_r, worst_r, 1'b0, out_of_order));
						cut_given    = 1'b1;
						known_b      = '0;
						known_r      = '0;
						resid_b_left = '0;
						resid_r_left = '0;
						walk_emitted = 1'b1;
					end
					open_key = lk + 1'b1;
					carry_b  = pb;
					carry_r  = pr;
				end
				next_key = lk + 1'b1;
				// out of order leaf with no cut reports its own keys
				if (!cut_given && out_of_order)
					add_due(partition_of(fk, lk, '0, '0, '0, '0, 1'b0, 1'b1));
			end
			MODE_INNER: begin
				known_b = clamp_b(known_b, rb);
				known_r = clamp_r(known_r, rr);
			end
			MODE_FINISH: begin
				if (known_b != '0)
					add_due(partition_of(open_key, KEY_MAX, known_b,
						clamp_b(known_b, carry_b), known_r, clamp_r(known_r, carry_r),
						1'b1, 1'b0));
				else if (!walk_emitted)
					add_due(partition_of('0, KEY_MAX, '0, '0, '0, '0, 1'b1, 1'b0));
				start_walk();
			end
			default: begin
			end
		endcase
	endtask

	// beat monitor: partitions first, then registers, then items
	always @(posedge clk or negedge arst_n) begin : watch_beats
		result_t got;
		result_t want;
		if (!arst_n) begin
			byte_limit = '0;
			ref_limit  = '0;
			resid_b    = '0;
			resid_r    = '0;
			start_walk();
			due_parts.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.part_first_key = m_tdata[0 +: KEY_W];
				got.part_last_key  = m_tdata[KEY_W +: KEY_W];
				got.min_bytes      = m_tdata[OUT_MINB +: BYTE_W];
				got.max_bytes      = m_tdata[OUT_MAXB +: BYTE_W];
				got.min_referents  = m_tdata[OUT_MINR +: REF_W];
				got.max_referents  = m_tdata[OUT_MAXR +: REF_W];
				got.is_final       = m_tlast;
				got.order_error    = m_tuser;
				if (due_parts.size() == 0) begin
					mismatches++;
					$display("%0t: partition beat with none due: keys %h..%h ", $time,
						got.part_first_key, got.part_last_key, "bytes %h/%h refs %h/%h ",
						got.min_bytes, got.max_bytes, got.min_referents, got.max_referents,
						"final %b err %b", got.is_final, got.order_error);
				end else begin
					want = due_parts.pop_front();
					if (got !== want) begin
						mismatches++;
						$display("%0t: partition mismatch, expected keys %h..%h ", $time,
							want.part_first_key, want.part_last_key, "bytes %h/%h refs %h/%h ",
							want.min_bytes, want.max_bytes, want.min_referents,
							want.max_referents, "final %b err %b; actual keys %h..%h ",
							want.is_final, want.order_error, got.part_first_key,
							got.part_last_key, "bytes %h/%h refs %h/%h final %b err %b",
							got.min_bytes, got.max_bytes, got.min_referents,
							got.max_referents, got.is_final, got.order_error);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BYTE_LIMIT: byte_limit = cfg_data[BYTE_W-1:0];
					REG_REF_LIMIT:  ref_limit  = cfg_data[REF_W-1:0];
					REG_RESID_B: begin
						resid_b = cfg_data[BYTE_W-1:0];
						if (!walk_emitted) resid_b_left = resid_b;
					end
					REG_RESID_R: begin
						resid_r = cfg_data[REF_W-1:0];
						if (!walk_emitted) resid_r_left = resid_r;
					end
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready)
				predict_partition(s_tuser, s_tdata[0 +: KEY_W], s_tdata[KEY_W +: KEY_W],
					s_tdata[IN_RB +: BYTE_W], s_tdata[IN_RR +: REF_W],
					s_tdata[IN_PB +: BYTE_W], s_tdata[IN_PR +: REF_W]);
			pending <= due_parts.size();
		end
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: key range partition collector stimulus and verdict
// Drives a directed walk over the special cases, then randomized walks of
// leaf, inner, finish and unused items under several limit settings, with
// random gaps on the item side and random stalls on the partition side.
// ----------------------------------------------------------------------------
module testbench;
	import krpc_pkg::*;

	localparam int DRAIN_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 75;

	typedef enum {CNT_SMALL, CNT_HUGE, CNT_WIDE} count_scale_e;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [MODE_W-1:0]     s_tuser   = MODE_LEAF;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_BYTE_LIMIT;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int           fail_count;
	int           pending;
	int           items_sent  = 0;
	int           quiet       = 0;
	int           rx_hold     = 0;
	logic         tx_steady   = 1'b0;
	logic         rx_steady   = 1'b0;
	count_scale_e count_scale = CNT_SMALL;

	key_range_partition_collector_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	partition_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int unsigned gap_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [BYTE_W-1:0] pick_bytes();
		logic [KEY_W-1:0] w;
		int unsigned      r;
		w = rand_key();
		r = $urandom_range(0, 99);
		if (r < 15) return '0;
		if (r < 25 || count_scale == CNT_WIDE) return w[BYTE_W-1:0];
		if (count_scale == CNT_HUGE) return BYTE_MAX - $urandom_range(0, 1000);
		return BYTE_W'($urandom_range(1, 400));
	endfunction

	function automatic logic [REF_W-1:0] pick_refs();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15) return '0;
		if (r < 25 || count_scale == CNT_WIDE) return $urandom;
		if (count_scale == CNT_HUGE) return REF_MAX - $urandom_range(0, 100);
		return $urandom_range(1, 60);
	endfunction

	// distance from first to last key of a leaf
	function automatic logic [KEY_W-1:0] pick_span();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return KEY_W'($urandom_range(0, 1000));
		return rand_key() >> $urandom_range(1, 63);
	endfunction

	// partition side: random stalls unless in a steady stretch
	always @(posedge clk) begin
		if (rx_hold != 0)
			rx_hold <= rx_hold - 1;
		else if (m_tready && !rx_steady && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			rx_hold  <= gap_cycles();
		end else
			m_tready <= 1'b1;
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else if (quiet == WATCHDOG_LIMIT) begin
			$display("key_range_partition_collector_top test failed");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	// one item beat, valid kept high across back-to-back beats
	task automatic send_item(input logic [MODE_W-1:0] mode,
		input logic [KEY_W-1:0] fk, input logic [KEY_W-1:0] lk,
		input logic [BYTE_W-1:0] rb, input logic [REF_W-1:0] rr,
		input logic [BYTE_W-1:0] pb, input logic [REF_W-1:0] pr);
		int unsigned gap;
		gap = tx_steady ? 0 : gap_cycles();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {pr, pb, rr, rb, lk, fk};
		do @(posedge clk); while (!s_tready);
		if (mode != MODE_UNUSED) items_sent++;
	endtask

	task automatic send_random(input logic [MODE_W-1:0] mode);
		send_item(mode, rand_key(), rand_key(), pick_bytes(), pick_refs(), pick_bytes(),
			pick_refs());
	endtask

	// hold items back until every partition due has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all four registers on an idle block
	task automatic load_limits(input logic [BYTE_W-1:0] blim, input logic [REF_W-1:0] rlim,
		input logic [BYTE_W-1:0] resb, input logic [REF_W-1:0] resr);
		logic [CFG_IDX_W-1:0]  idx [4];
		logic [CFG_DATA_W-1:0] val [4];
		idx[0] = REG_BYTE_LIMIT;
		idx[1] = REG_REF_LIMIT;
		idx[2] = REG_RESID_B;
		idx[3] = REG_RESID_R;
		val[0] = blim;
		val[1] = CFG_DATA_W'(rlim);
		val[2] = resb;
		val[3] = CFG_DATA_W'(resr);
		drain();
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// mostly in-order leaves with inner counts, some broken items, then finish
	task automatic run_walk();
		logic [KEY_W-1:0] key_next;
		logic [KEY_W-1:0] fk;
		logic [KEY_W-1:0] lk;
		int unsigned      n;
		int unsigned      r;
		key_next = '0;
		n = $urandom_range(2, 24);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 62 || (r >= 82 && r < 90)) begin
				if (r < 62)
					fk = key_next;
				else
					fk = (r < 86) ? rand_key() : key_next + 1'b1;
				lk = ($urandom_range(0, 19) == 0) ? KEY_MAX : fk + pick_span();
				send_item(MODE_LEAF, fk, lk, pick_bytes(), pick_refs(), pick_bytes(),
					pick_refs());
				key_next = lk + 1'b1;
			end else if (r < 82)
				send_random(MODE_INNER);
			else if (r < 95)
				send_random(MODE_UNUSED);
			else begin
				send_random(MODE_FINISH);
				key_next = '0;
			end
		end
		send_random(MODE_FINISH);
	endtask

	// directed walk: zero limits, top limits, then residuals
	task automatic run_directed();
		// finish on a fresh walk gives the empty partition
		send_item(MODE_FINISH, '0, '0, '0, '0, '0, '0);
		// cut with no known bytes, then counts carried into the next cut
		send_item(MODE_LEAF, 64'd0, 64'd9, '0, 32'd4, 48'd2, 32'd1);
		send_item(MODE_INNER, '0, '0, 48'd5, 32'd3, '0, '0);
		send_item(MODE_LEAF, 64'd10, 64'd19, 48'd7, '0, '0, '0);
		// out of order leaf that still closes a partition
		send_item(MODE_LEAF, 64'd500, 64'd600, 48'd1, 32'd1, '0, '0);
		send_random(MODE_UNUSED);
		// nothing left to give
		send_item(MODE_FINISH, KEY_MAX, KEY_MAX, BYTE_MAX, REF_MAX, BYTE_MAX, REF_MAX);

		load_limits(BYTE_MAX, REF_MAX, '0, '0);
		send_item(MODE_LEAF, 64'd0, 64'd99, 48'd1, 32'd1, '0, '0);
		// out of order leaf without a cut
		send_item(MODE_LEAF, 64'd7, 64'd200, '0, '0, '0, '0);
		send_item(MODE_INNER, '0, '0, BYTE_MAX, REF_MAX, '0, '0);
		// saturated sums, last key at the top so the open key wraps
		send_item(MODE_LEAF, 64'd201, KEY_MAX, BYTE_MAX, REF_MAX, BYTE_MAX, REF_MAX);
		send_item(MODE_LEAF, 64'd0, 64'd5, 48'd3, 32'd2, '0, '0);
		send_item(MODE_LEAF, 64'd6, 64'd10, 48'd2, 32'd1, '0, '0);
		send_item(MODE_FINISH, '0, '0, '0, '0, '0, '0);

		// residual pushes the first cut early
		load_limits(48'd1000, REF_MAX, 48'd900, '0);
		send_item(MODE_LEAF, 64'd0, 64'd50, 48'd200, 32'd5, '0, '0);
		// residual write mid walk must not reload
		load_limits(48'd1000, REF_MAX, 48'd500, 32'd7);
		send_item(MODE_LEAF, 64'd51, 64'd60, 48'd200, 32'd5, '0, '0);
		send_item(MODE_LEAF, KEY_MAX, KEY_MAX, '0, '0, '0, '0);
		send_item(MODE_INNER, rand_key(), rand_key(), 48'd3, 32'd3, '0, '0);
		send_item(MODE_FINISH, '0, '0, '0, '0, '0, '0);
	endtask

	// random phases, each with its own limits; idle patterns vary between phases
	task automatic run_phase(input int phase);
		int target;
		case (phase)
			0: begin
				tx_steady   = 1'b0;
				rx_steady  <= 1'b0;
				count_scale = CNT_SMALL;
				load_limits(BYTE_W'($urandom_range(500, 3000)), $urandom_range(40, 300),
					'0, '0);
			end
			1: begin
				tx_steady   = 1'b1;
				rx_steady  <= 1'b1;
				count_scale = CNT_SMALL;
				load_limits(BYTE_MAX, $urandom_range(20, 200), '0, $urandom_range(0, 100));
			end
			2: begin
				tx_steady   = 1'b0;
				rx_steady  <= 1'b0;
				count_scale = CNT_SMALL;
				load_limits('0, '0, '0, '0);
			end
			3: begin
				tx_steady   = 1'b0;
				rx_steady  <= 1'b0;
				count_scale = CNT_HUGE;
				load_limits(BYTE_MAX, REF_MAX, BYTE_MAX, REF_MAX);
			end
			4: begin
				tx_steady   = 1'b0;
				rx_steady  <= 1'b1;
				count_scale = CNT_SMALL;
				load_limits(BYTE_W'($urandom_range(1000, 4000)), $urandom_range(100, 400),
					BYTE_W'($urandom_range(0, 2000)), $urandom_range(0, 200));
			end
			default: begin
				tx_steady   = 1'b1;
				rx_steady  <= 1'b0;
				count_scale = CNT_WIDE;
				load_limits(pick_bytes(), pick_refs(), pick_bytes() >> $urandom_range(0, 47),
					pick_refs() >> $urandom_range(0, 31));
			end
		endcase
		target = items_sent + PHASE_ITEMS;
		while (items_sent < target) run_walk();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < 6; p++) run_phase(p);
		drain();
		if (fail_count == 0 && pending == 0)
			$display("key_range_partition_collector_top test passed");
		else
			$display("key_range_partition_collector_top test failed");
		$finish;
	end

endmodule
